@@ rtl/wzh_pkg.sv @@
package wzh_pkg;

    typedef enum logic [2:0] {
        OP_NEW,
        OP_DISPOSE,
        OP_HIDE,
        OP_SHOW,
        OP_RAISE,
        OP_MOVE,
        OP_HIT,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_PART,
        BK_ACT
    } t_back_state;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_LISTED  = 2'd2;

    localparam logic [2:0] PART_DESK    = 3'd0;
    localparam logic [2:0] PART_CONTENT = 3'd1;
    localparam logic [2:0] PART_DRAG    = 3'd2;
    localparam logic [2:0] PART_GROW    = 3'd3;
    localparam logic [2:0] PART_GOAWAY  = 3'd4;
    localparam logic [2:0] PART_ZOOM    = 3'd5;

    localparam logic [1:0] STYLE_GROW      = 2'd1;
    localparam logic [1:0] STYLE_ZOOM_GROW = 2'd2;
    localparam logic [1:0] STYLE_ZOOM      = 2'd3;

    localparam int SLOT_W = 4;

    typedef struct packed {
        logic [2:0]         mode;
        logic [3:0]         slot;
        logic signed [15:0] pos_h;
        logic signed [15:0] pos_v;
        logic signed [15:0] struct_bottom;
        logic signed [15:0] struct_right;
        logic signed [15:0] content_top;
        logic signed [15:0] content_left;
        logic signed [15:0] content_bottom;
        logic signed [15:0] content_right;
        logic               close_box;
        logic [1:0]         box_style;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] part;
        logic       hit_valid;
        logic [3:0] hit_slot;
        logic       active_valid;
        logic [3:0] active_slot;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [3:0]         slot;
        logic signed [15:0] pos_h;
        logic signed [15:0] pos_v;
        logic signed [15:0] struct_bottom;
        logic signed [15:0] struct_right;
        logic signed [15:0] content_top;
        logic signed [15:0] content_left;
        logic signed [15:0] content_bottom;
        logic signed [15:0] content_right;
        logic               close_box;
        logic [1:0]         box_style;
    } t_cmd;

    typedef struct packed {
        logic valid;
    } t_q_ctrl;

endpackage

@@ rtl/wzh_if.sv @@
interface wzh_in_if;
    import wzh_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface wzh_out_if;
    import wzh_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/wzh_front.sv @@
module wzh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wzh_in_if.sink        i_in,
    input  logic          i_q_pop,
    output logic          o_q_valid,
    output wzh_pkg::t_cmd o_q_cmd
);
    import wzh_pkg::*;

    // two-entry queue between accept and execute
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       cmd;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_cmd    = r_mem[r_rp];

    always_comb begin
        cmd.slot           = i_in.payload.slot;
        cmd.pos_h          = i_in.payload.pos_h;
        cmd.pos_v          = i_in.payload.pos_v;
        cmd.struct_bottom  = i_in.payload.struct_bottom;
        cmd.struct_right   = i_in.payload.struct_right;
        cmd.content_top    = i_in.payload.content_top;
        cmd.content_left   = i_in.payload.content_left;
        cmd.content_bottom = i_in.payload.content_bottom;
        cmd.content_right  = i_in.payload.content_right;
        cmd.close_box      = i_in.payload.close_box;
        cmd.box_style      = i_in.payload.box_style;
        // every mode code has an operation, the unused one maps to OP_NONE
        cmd.op             = t_op'(i_in.payload.mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            case ({push, pop})
                2'b10: r_cnt <= r_cnt + 2'd1;
                2'b01: r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= cmd;
    end

endmodule

@@ rtl/wzh_back.sv @@
module wzh_back #(
    parameter int N_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wzh_pkg::t_q_ctrl  i_q,
    input  wzh_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    wzh_out_if.source         o_out
);
    import wzh_pkg::*;

    localparam int SIW = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
    localparam int CW  = $clog2(N_SLOTS + 1);

    t_back_state r_state, n_state;

    // z-order list, front at entry 0
    logic [SIW-1:0]     r_list [N_SLOTS];
    logic [CW-1:0]      r_count;
    logic [N_SLOTS-1:0] r_mask;

    // per-window cells
    logic signed [15:0] r_st [N_SLOTS];
    logic signed [15:0] r_sl [N_SLOTS];
    logic signed [15:0] r_sb [N_SLOTS];
    logic signed [15:0] r_sr [N_SLOTS];
    logic signed [15:0] r_ct [N_SLOTS];
    logic signed [15:0] r_cl [N_SLOTS];
    logic signed [15:0] r_cb [N_SLOTS];
    logic signed [15:0] r_cr [N_SLOTS];
    logic [N_SLOTS-1:0] r_vis;
    logic [N_SLOTS-1:0] r_close;
    logic [1:0]         r_style [N_SLOTS];

    t_cmd           r_cmd;
    logic [1:0]     r_status;
    logic [2:0]     r_part;
    logic           r_hit_valid;
    logic [SIW-1:0] r_hit_slot;
    t_out_item      r_out;
    logic           r_out_valid;

    logic           exec_en, part_en, act_load;
    logic [SIW-1:0] sidx;
    logic           in_range, listed, do_write;
    logic [N_SLOTS-1:0] pos_hit, at_or_after, s_in;
    logic [SIW-1:0] list_del [N_SLOTS];
    logic [SIW-1:0] list_raise [N_SLOTS];
    logic [SIW-1:0] list_push [N_SLOTS];
    logic           hit_found, act_found;
    logic [SIW-1:0] hit_w, act_w;
    logic [1:0]     status;
    logic signed [15:0] dh, dv;
    logic signed [15:0] h, v, tb, gb;
    logic [2:0]     part;

    assign sidx     = r_cmd.slot[SIW-1:0];
    assign in_range = ({1'b0, r_cmd.slot} < 5'(N_SLOTS));
    assign listed   = in_range && r_mask[sidx];
    assign h        = r_cmd.pos_h;
    assign v        = r_cmd.pos_v;

    // position of the slot in the list and list rewrites
    always_comb begin
        for (int i = 0; i < N_SLOTS; i++) begin
            pos_hit[i] = (CW'(i) < r_count) && (r_list[i] == sidx);
            s_in[i] = r_vis[i] && v >= r_st[i] && v < r_sb[i]
                      && h >= r_sl[i] && h < r_sr[i];
        end
        at_or_after[0] = pos_hit[0];
        for (int i = 1; i < N_SLOTS; i++) at_or_after[i] = at_or_after[i-1] | pos_hit[i];
        for (int i = 0; i < N_SLOTS; i++) begin
            if (i + 1 < N_SLOTS && at_or_after[i]) list_del[i] = r_list[i+1];
            else list_del[i] = r_list[i];
            if (i == 0) begin
                list_raise[i] = sidx;
                list_push[i]  = sidx;
            end else begin
                list_raise[i] = at_or_after[i-1] ? r_list[i] : r_list[i-1];
                list_push[i]  = r_list[i-1];
            end
        end
    end

    // frontmost hit and frontmost visible window
    always_comb begin
        hit_found = 1'b0;
        hit_w     = '0;
        act_found = 1'b0;
        act_w     = '0;
        for (int i = N_SLOTS - 1; i >= 0; i--) begin
            if (CW'(i) < r_count && s_in[r_list[i]]) begin
                hit_found = 1'b1;
                hit_w     = r_list[i];
            end
            if (CW'(i) < r_count && r_vis[r_list[i]]) begin
                act_found = 1'b1;
                act_w     = r_list[i];
            end
        end
    end

    always_comb begin
        status   = ST_OK;
        do_write = 1'b0;
        case (r_cmd.op)
            OP_NEW: begin
                if (!in_range) status = ST_MISSING;
                else if (listed) status = ST_LISTED;
                else do_write = 1'b1;
            end
            OP_DISPOSE, OP_HIDE, OP_SHOW, OP_RAISE, OP_MOVE: begin
                if (!listed) status = ST_MISSING;
                else do_write = 1'b1;
            end
            default: status = ST_OK;
        endcase
        dh = h - r_sl[sidx];
        dv = v - r_st[sidx];
    end

    // part code of the hit window
    always_comb begin
        tb = r_ct[r_hit_slot] - r_st[r_hit_slot];
        if (tb < 16'sd1) tb = 16'sd1;
        gb = r_sb[r_hit_slot] - r_cb[r_hit_slot];
        if (gb < 16'sd1) gb = 16'sd1;
        if (v >= r_ct[r_hit_slot] && v < r_cb[r_hit_slot]
            && h >= r_cl[r_hit_slot] && h < r_cr[r_hit_slot]) begin
            part = PART_CONTENT;
        end else if (r_close[r_hit_slot] && h >= r_sl[r_hit_slot]
                     && h < 16'(r_sl[r_hit_slot] + tb)
                     && v >= r_st[r_hit_slot] && v < r_ct[r_hit_slot]) begin
            part = PART_GOAWAY;
        end else if ((r_style[r_hit_slot] == STYLE_ZOOM_GROW
                      || r_style[r_hit_slot] == STYLE_ZOOM)
                     && h >= 16'(r_sr[r_hit_slot] - tb) && h < r_sr[r_hit_slot]
                     && v >= r_st[r_hit_slot] && v < r_ct[r_hit_slot]) begin
            part = PART_ZOOM;
        end else if ((r_style[r_hit_slot] == STYLE_GROW
                      || r_style[r_hit_slot] == STYLE_ZOOM_GROW)
                     && h >= 16'(r_sr[r_hit_slot] - gb) && h < r_sr[r_hit_slot]
                     && v >= 16'(r_sb[r_hit_slot] - gb) && v < r_sb[r_hit_slot]) begin
            part = PART_GROW;
        end else begin
            part = PART_DRAG;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_q.valid) n_state = BK_EXEC;
            BK_EXEC: n_state = (r_cmd.op == OP_HIT && hit_found) ? BK_PART : BK_ACT;
            BK_PART: n_state = BK_ACT;
            BK_ACT:  if (act_load) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop  = 1'b0;
        exec_en  = 1'b0;
        part_en  = 1'b0;
        act_load = 1'b0;
        case (r_state)
            BK_IDLE: o_q_pop = i_q.valid;
            BK_EXEC: exec_en = 1'b1;
            BK_PART: part_en = 1'b1;
            BK_ACT:  act_load = !r_out_valid || o_out.ready;
            default: o_q_pop = 1'b0;
        endcase
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_en && do_write) begin
                case (r_cmd.op)
                    OP_NEW: begin
                        r_count      <= r_count + CW'(1);
                        r_mask[sidx] <= 1'b1;
                    end
                    OP_DISPOSE: begin
                        r_count      <= r_count - CW'(1);
                        r_mask[sidx] <= 1'b0;
                    end
                    default: r_count <= r_count;
                endcase
            end
            if (act_load) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_cmd;
        if (exec_en) begin
            r_status    <= status;
            r_part      <= PART_DESK;
            r_hit_valid <= (r_cmd.op == OP_HIT) && hit_found;
            r_hit_slot  <= (r_cmd.op == OP_HIT && hit_found) ? hit_w : '0;
        end
        if (part_en) r_part <= part;
        if (exec_en && do_write) begin
            case (r_cmd.op)
                OP_NEW: begin
                    r_st[sidx]    <= r_cmd.pos_v;
                    r_sl[sidx]    <= r_cmd.pos_h;
                    r_sb[sidx]    <= r_cmd.struct_bottom;
                    r_sr[sidx]    <= r_cmd.struct_right;
                    r_ct[sidx]    <= r_cmd.content_top;
                    r_cl[sidx]    <= r_cmd.content_left;
                    r_cb[sidx]    <= r_cmd.content_bottom;
                    r_cr[sidx]    <= r_cmd.content_right;
                    r_vis[sidx]   <= 1'b1;
                    r_close[sidx] <= r_cmd.close_box;
                    r_style[sidx] <= r_cmd.box_style;
                    r_list        <= list_push;
                end
                OP_DISPOSE: r_list <= list_del;
                OP_HIDE:    r_vis[sidx] <= 1'b0;
                OP_SHOW:    r_vis[sidx] <= 1'b1;
                OP_RAISE:   r_list <= list_raise;
                OP_MOVE: begin
                    r_st[sidx] <= r_st[sidx] + dv;
                    r_sb[sidx] <= r_sb[sidx] + dv;
                    r_ct[sidx] <= r_ct[sidx] + dv;
                    r_cb[sidx] <= r_cb[sidx] + dv;
                    r_sl[sidx] <= r_sl[sidx] + dh;
                    r_sr[sidx] <= r_sr[sidx] + dh;
                    r_cl[sidx] <= r_cl[sidx] + dh;
                    r_cr[sidx] <= r_cr[sidx] + dh;
                end
                default: r_vis <= r_vis;
            endcase
        end
        if (act_load) begin
            r_out.status       <= r_status;
            r_out.part         <= r_part;
            r_out.hit_valid    <= r_hit_valid;
            r_out.hit_slot     <= SLOT_W'(r_hit_slot);
            r_out.active_valid <= act_found;
            r_out.active_slot  <= SLOT_W'(act_w);
        end
    end

endmodule

@@ rtl/window_zorder_hit_test.sv @@
// z-ordered window table with point hit test
// channels: i_in takes one command word (mode, slot, point or rectangles,
//   close box, box style); o_out gives exactly one result word per command
//   (status, hit part, hit window, active window)
// a front stage accepts words into a two-entry queue; the back end pops one
//   word at a time and runs it against the window cells
// sequence: the back end pops a word in its idle state, runs it in exec, decodes
//   the hit part in a part state for a hit test that finds a window, then loads
//   the result register in its active search state; it pops the next word only
//   after that load, so the back end sequencer (pop, exec, part, active search) sets the pace
// reset: synchronous active low; empties the queue, the window list and the
//   listed mask, drops any pending result
// stall: a held result sits in the output register; the back end can finish
//   the next word up to its active search and waits there, while the front
//   keeps accepting until its queue is full
// only slots below MAX_WINDOWS (and below 16) can ever be listed
module window_zorder_hit_test #(
    parameter int MAX_WINDOWS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wzh_in_if.sink     i_in,
    wzh_out_if.source  o_out
);
    import wzh_pkg::*;

    // slot field is 4 bits, so at most 16 cells are ever used
    localparam int N_SLOTS = (MAX_WINDOWS < 16) ? MAX_WINDOWS : 16;

    t_q_ctrl q_ctrl;
    t_cmd    q_cmd;
    logic    q_valid;
    logic    q_pop;

    // accept and decode side
    wzh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_pop   (q_pop),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd)
    );

    assign q_ctrl.valid = q_valid;

    // list, cells and result register
    wzh_back #(
        .N_SLOTS (N_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_ctrl),
        .i_q_cmd (q_cmd),
        .o_q_pop (q_pop),
        .o_out   (o_out)
    );

endmodule
